// ----- rtl/core/spk_pkg.sv -----
package spk_pkg;

  localparam int DIM_W  = 13;
  localparam int GUT_W  = 8;
  localparam int PAD_W  = 14;
  localparam int POS_W  = 12;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_PAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_PAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GUTTER      = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [GUT_W-1:0] GUTTER_RESET = 8'd1;

  typedef struct packed {
    logic [DIM_W-1:0] page_width;
    logic [DIM_W-1:0] page_height;
    logic [GUT_W-1:0] gutter;
  } spk_cfg_t;

  typedef struct packed {
    logic fits;
    logic better;
  } spk_fit_t;

endpackage

// ----- rtl/core/spk_ram.sv -----
module spk_ram #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/spk_fit.sv -----
module spk_fit #(
  parameter int COORD_BITS = 13
) (
  input  logic [COORD_BITS-1:0]        band,
  input  logic [COORD_BITS-1:0]        cursor,
  input  logic [COORD_BITS-1:0]        best_band,
  input  logic                         found,
  input  logic [spk_pkg::PAD_W-1:0]    pad_w,
  input  logic [spk_pkg::PAD_W-1:0]    pad_h,
  input  logic [spk_pkg::DIM_W-1:0]    page_width,
  output spk_pkg::spk_fit_t            fit
);

  import spk_pkg::*;

  localparam int SUM_W = (COORD_BITS > PAD_W ? COORD_BITS : PAD_W) + 1;

  logic [SUM_W-1:0] row_end;
  logic             band_ok;
  logic             row_ok;

  assign row_end    = SUM_W'(cursor) + SUM_W'(pad_w);
  assign band_ok    = SUM_W'(band) >= SUM_W'(pad_h);
  assign row_ok     = row_end <= SUM_W'(page_width);
  assign fit.fits   = band_ok && row_ok;
  assign fit.better = !found || (band < best_band);

endmodule

// ----- rtl/core/spk_regs.sv -----
module spk_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spk_pkg::ADDR_W-1:0]  paddr,
  input  logic [spk_pkg::DATA_W-1:0]  pwdata,
  output logic [spk_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output spk_pkg::spk_cfg_t           cfg
);

  import spk_pkg::*;

  spk_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.page_width  <= '0;
      cfg_r.page_height <= '0;
      cfg_r.gutter      <= GUTTER_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PAGE_WIDTH:  cfg_r.page_width  <= pwdata[DIM_W-1:0];
        REG_PAGE_HEIGHT: cfg_r.page_height <= pwdata[DIM_W-1:0];
        REG_GUTTER:      cfg_r.gutter      <= pwdata[GUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAGE_WIDTH:  prdata = DATA_W'(cfg_r.page_width);
      REG_PAGE_HEIGHT: prdata = DATA_W'(cfg_r.page_height);
      REG_GUTTER:      prdata = DATA_W'(cfg_r.gutter);
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/shelf_best_fit_rect_packer_core.sv -----
// A clear or a bad box size answers from the check state; an allocate goes through
// the check, scan and decide states, the scan reading every open shelf.
// The block takes one item at a time; busy drops in the cycle of the result beat.
// The scan reads one shelf entry per cycle from the shelf memory.
// Synchronous active-low reset empties the shelf table and restores the control and config registers.
// The result beat lasts one cycle and the receiver cannot stall it.
module shelf_best_fit_rect_packer_core #(
  parameter int MAX_SHELVES = 64,
  parameter int COORD_BITS  = 13
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_opcode,
  input  logic [spk_pkg::DIM_W-1:0]   in_box_width,
  input  logic [spk_pkg::DIM_W-1:0]   in_box_height,
  output logic                        out_strobe,
  output logic                        out_granted,
  output logic [spk_pkg::POS_W-1:0]   out_pos_x,
  output logic [spk_pkg::POS_W-1:0]   out_pos_y,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spk_pkg::ADDR_W-1:0]  paddr,
  input  logic [spk_pkg::DATA_W-1:0]  pwdata,
  output logic [spk_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  import spk_pkg::*;

  localparam int IDX_W = MAX_SHELVES > 1 ? $clog2(MAX_SHELVES) : 1;
  localparam int CNT_W = $clog2(MAX_SHELVES + 1);
  localparam int ENT_W = 3 * COORD_BITS;
  localparam int SUM_W = (COORD_BITS > PAD_W ? COORD_BITS : PAD_W) + 1;
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  spk_cfg_t cfg;
  spk_fit_t fit;

  logic [1:0]            state_r, state_nxt;
  logic                  op_r, op_nxt;
  logic [DIM_W-1:0]      w_r, w_nxt, h_r, h_nxt;
  logic [PAD_W-1:0]      pw_r, pw_nxt, ph_r, ph_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [COORD_BITS-1:0] pb_r, pb_nxt;
  logic [CNT_W-1:0]      iss_r, iss_nxt;
  logic                  vld_r, vld_nxt;
  logic [IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [COORD_BITS-1:0] best_top_r, best_top_nxt;
  logic [COORD_BITS-1:0] best_band_r, best_band_nxt;
  logic [COORD_BITS-1:0] best_cur_r, best_cur_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  logic                  out_granted_r, out_granted_nxt;
  logic [POS_W-1:0]      out_pos_x_r, out_pos_x_nxt;
  logic [POS_W-1:0]      out_pos_y_r, out_pos_y_nxt;

  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [ENT_W-1:0]      wdata;
  logic [IDX_W-1:0]      raddr;
  logic [ENT_W-1:0]      rdata;
  logic                  rd_en;

  logic [COORD_BITS-1:0] ent_top, ent_band, ent_cur;
  logic [PAD_W-1:0]      pad_w, pad_h;
  logic                  reject;
  logic [SUM_W-1:0]      bottom_sum;
  logic                  no_room;
  logic [COORD_BITS-1:0] cur_base, cur_sat, ph_trunc;
  logic [SUM_W-1:0]      cur_sum;

  spk_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spk_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SHELVES)
  ) u_shelf_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ent_top  = rdata[3*COORD_BITS-1:2*COORD_BITS];
  assign ent_band = rdata[2*COORD_BITS-1:COORD_BITS];
  assign ent_cur  = rdata[COORD_BITS-1:0];

  spk_fit #(
    .COORD_BITS (COORD_BITS)
  ) u_fit (
    .band       (ent_band),
    .cursor     (ent_cur),
    .best_band  (best_band_r),
    .found      (found_r),
    .pad_w      (pw_r),
    .pad_h      (ph_r),
    .page_width (cfg.page_width),
    .fit        (fit)
  );

  assign pad_w  = PAD_W'(w_r) + PAD_W'(cfg.gutter);
  assign pad_h  = PAD_W'(h_r) + PAD_W'(cfg.gutter);
  assign reject = (w_r == '0) || (h_r == '0) || (w_r > cfg.page_width)
                  || (h_r > cfg.page_height);

  assign bottom_sum = SUM_W'(pb_r) + SUM_W'(ph_r);
  assign no_room    = (bottom_sum > SUM_W'(cfg.page_height))
                      || (count_r >= CNT_W'(MAX_SHELVES));
  assign ph_trunc   = COORD_BITS'({{COORD_BITS{1'b0}}, ph_r});

  assign cur_base = found_r ? best_cur_r : '0;
  assign cur_sum  = SUM_W'(cur_base) + SUM_W'(pw_r);
  assign cur_sat  = (cur_sum > SUM_W'(COORD_MAX)) ? COORD_MAX : cur_sum[COORD_BITS-1:0];

  assign rd_en = (state_r == ST_SCAN) && (iss_r < count_r);
  assign raddr = iss_r[IDX_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    w_nxt           = w_r;
    h_nxt           = h_r;
    pw_nxt          = pw_r;
    ph_nxt          = ph_r;
    count_nxt       = count_r;
    pb_nxt          = pb_r;
    iss_nxt         = iss_r;
    vld_nxt         = 1'b0;
    cmp_idx_nxt     = cmp_idx_r;
    found_nxt       = found_r;
    best_idx_nxt    = best_idx_r;
    best_top_nxt    = best_top_r;
    best_band_nxt   = best_band_r;
    best_cur_nxt    = best_cur_r;
    out_strobe_nxt  = 1'b0;
    out_granted_nxt = out_granted_r;
    out_pos_x_nxt   = out_pos_x_r;
    out_pos_y_nxt   = out_pos_y_r;
    we              = 1'b0;
    waddr           = best_idx_r;
    wdata           = {best_top_r, best_band_r, cur_sat};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = in_opcode;
          w_nxt     = in_box_width;
          h_nxt     = in_box_height;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (op_r == OP_CLEAR) begin
          count_nxt       = '0;
          pb_nxt          = '0;
          out_strobe_nxt  = 1'b1;
          out_granted_nxt = 1'b1;
          out_pos_x_nxt   = '0;
          out_pos_y_nxt   = '0;
          state_nxt       = ST_IDLE;
        end else if (reject) begin
          out_strobe_nxt  = 1'b1;
          out_granted_nxt = 1'b0;
          out_pos_x_nxt   = '0;
          out_pos_y_nxt   = '0;
          state_nxt       = ST_IDLE;
        end else begin
          pw_nxt    = pad_w;
          ph_nxt    = pad_h;
          iss_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        vld_nxt     = rd_en;
        cmp_idx_nxt = raddr;
        if (rd_en) begin
          iss_nxt = iss_r + 1'b1;
        end
        if (vld_r && fit.fits && fit.better) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = cmp_idx_r;
          best_top_nxt  = ent_top;
          best_band_nxt = ent_band;
          best_cur_nxt  = ent_cur;
        end
        if (!rd_en && !vld_r) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = ST_IDLE;
        if (found_r) begin
          we              = 1'b1;
          out_granted_nxt = 1'b1;
          out_pos_x_nxt   = POS_W'({{POS_W{1'b0}}, best_cur_r});
          out_pos_y_nxt   = POS_W'({{POS_W{1'b0}}, best_top_r});
        end else if (no_room) begin
          out_granted_nxt = 1'b0;
          out_pos_x_nxt   = '0;
          out_pos_y_nxt   = '0;
        end else begin
          we              = 1'b1;
          waddr           = count_r[IDX_W-1:0];
          wdata           = {pb_r, ph_trunc, cur_sat};
          count_nxt       = count_r + 1'b1;
          pb_nxt          = bottom_sum[COORD_BITS-1:0];
          out_granted_nxt = 1'b1;
          out_pos_x_nxt   = '0;
          out_pos_y_nxt   = POS_W'({{POS_W{1'b0}}, pb_r});
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      pb_r         <= '0;
      vld_r        <= 1'b0;
      found_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pb_r         <= pb_nxt;
      vld_r        <= vld_nxt;
      found_r      <= found_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    w_r           <= w_nxt;
    h_r           <= h_nxt;
    pw_r          <= pw_nxt;
    ph_r          <= ph_nxt;
    iss_r         <= iss_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    best_idx_r    <= best_idx_nxt;
    best_top_r    <= best_top_nxt;
    best_band_r   <= best_band_nxt;
    best_cur_r    <= best_cur_nxt;
    out_granted_r <= out_granted_nxt;
    out_pos_x_r   <= out_pos_x_nxt;
    out_pos_y_r   <= out_pos_y_nxt;
  end

  assign busy        = state_r != ST_IDLE;
  assign out_strobe  = out_strobe_r;
  assign out_granted = out_granted_r;
  assign out_pos_x   = out_pos_x_r;
  assign out_pos_y   = out_pos_y_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("Result beat while the sequencer is still working.");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted item did not make the block busy.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SHELVES))
    else $error("Shelf count exceeds the table depth.");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_granted) |-> (out_pos_x == '0 && out_pos_y == '0))
    else $error("Refused result carries a nonzero position.");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (state_r == ST_SCAN))
    else $error("Shelf compare pending outside the scan.");

endmodule

// ----- sim/tb_shelf_best_fit_rect_packer_core.sv -----
`timescale 1ns / 100ps

module tb_shelf_best_fit_rect_packer_core;
  import spk_pkg::*;

  localparam int SHELVES        = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = SHELVES + 16;
  localparam int COORD_TOP      = (1 << DIM_W) - 1;

  localparam logic [1:0]       REG_UNMAPPED = 2'd3;
  localparam logic [DIM_W-1:0] DIM_MAX      = '1;

  typedef struct packed {
    logic             granted;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } placement_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_opcode;
  logic [DIM_W-1:0]  in_box_width;
  logic [DIM_W-1:0]  in_box_height;
  logic              out_strobe;
  logic              out_granted;
  logic [POS_W-1:0]  out_pos_x;
  logic [POS_W-1:0]  out_pos_y;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [DIM_W-1:0] shelf_y       [SHELVES];
  logic [DIM_W-1:0] shelf_band_px [SHELVES];
  logic [DIM_W-1:0] shelf_next_x  [SHELVES];
  int               shelves_open;
  logic [DIM_W-1:0] page_fill;
  logic [DIM_W-1:0] page_w_px;
  logic [DIM_W-1:0] page_h_px;
  logic [GUT_W-1:0] gutter_px;

  placement_t placements_due[$];
  placement_t due_now;
  int         errors;
  int         idle_cycles;

  shelf_best_fit_rect_packer_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_box_width  (in_box_width),
    .in_box_height (in_box_height),
    .out_strobe    (out_strobe),
    .out_granted   (out_granted),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void empty_shelves();
    for (int i = 0; i < SHELVES; i++) begin
      shelf_y[i]       = '0;
      shelf_band_px[i] = '0;
      shelf_next_x[i]  = '0;
    end
    shelves_open = 0;
    page_fill    = '0;
  endfunction

  function automatic placement_t place_box(input logic op, input logic [DIM_W-1:0] w,
                                           input logic [DIM_W-1:0] h);
    placement_t res;
    int         pad_w;
    int         pad_h;
    int         pick;
    int         next_x;
    bit         found;
    res   = '0;
    pick  = 0;
    found = 1'b0;
    if (op == OP_CLEAR) begin
      empty_shelves();
      res.granted = 1'b1;
      return res;
    end
    if (w == '0 || h == '0 || w > page_w_px || h > page_h_px) begin
      return res;
    end
    pad_w = int'(w) + int'(gutter_px);
    pad_h = int'(h) + int'(gutter_px);
    for (int i = 0; i < shelves_open; i++) begin
      if (int'(shelf_band_px[i]) >= pad_h &&
          int'(shelf_next_x[i]) + pad_w <= int'(page_w_px)) begin
        if (!found || shelf_band_px[i] < shelf_band_px[pick]) begin
          pick  = i;
          found = 1'b1;
        end
      end
    end
    if (!found) begin
      if (int'(page_fill) + pad_h > int'(page_h_px) || shelves_open >= SHELVES) begin
        return res;
      end
      pick                = shelves_open;
      shelf_y[pick]       = page_fill;
      shelf_band_px[pick] = DIM_W'(pad_h);
      shelf_next_x[pick]  = '0;
      shelves_open++;
      page_fill = DIM_W'(int'(page_fill) + pad_h);
    end
    res.granted = 1'b1;
    res.pos_x   = shelf_next_x[pick][POS_W-1:0];
    res.pos_y   = shelf_y[pick][POS_W-1:0];
    next_x      = int'(shelf_next_x[pick]) + pad_w;
    shelf_next_x[pick] = (next_x > COORD_TOP) ? DIM_MAX : DIM_W'(next_x);
    return res;
  endfunction

  task automatic send_item(input logic op, input logic [DIM_W-1:0] w,
                           input logic [DIM_W-1:0] h);
    @(negedge clk);
    start         <= 1'b1;
    in_opcode     <= op;
    in_box_width  <= w;
    in_box_height <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    placements_due.insert(placements_due.size(), place_box(op, w, h));
  endtask

  task automatic rest(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic quiesce();
    rest(1);
    while (placements_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_PAGE_WIDTH:  page_w_px = value[DIM_W-1:0];
      REG_PAGE_HEIGHT: page_h_px = value[DIM_W-1:0];
      REG_GUTTER:      gutter_px = value[GUT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_page(input int width, input int height, input int pad);
    quiesce();
    write_reg(REG_PAGE_WIDTH, DATA_W'(width));
    write_reg(REG_PAGE_HEIGHT, DATA_W'(height));
    write_reg(REG_GUTTER, DATA_W'(pad));
    send_item(OP_CLEAR, '0, '0);
  endtask

  task automatic test_reset_defaults();
    send_item(OP_ALLOC, 13'd1, 13'd1);
    send_item(OP_CLEAR, DIM_MAX, DIM_MAX);
    send_item(OP_ALLOC, 13'd1, 13'd1);
  endtask

  task automatic test_directed_shelves();
    set_page(256, 64, 2);
    send_item(OP_ALLOC, 13'd0, 13'd10);
    send_item(OP_ALLOC, 13'd10, 13'd0);
    send_item(OP_ALLOC, 13'd257, 13'd10);
    send_item(OP_ALLOC, 13'd10, 13'd65);
    send_item(OP_ALLOC, DIM_MAX, DIM_MAX);
    send_item(OP_ALLOC, 13'd256, 13'd10);
    send_item(OP_ALLOC, 13'd10, 13'd10);
    send_item(OP_ALLOC, 13'd20, 13'd5);
    send_item(OP_ALLOC, 13'd10, 13'd20);
    send_item(OP_ALLOC, 13'd10, 13'd8);
    send_item(OP_ALLOC, 13'd10, 13'd12);
    send_item(OP_ALLOC, 13'd10, 13'd17);
    send_item(OP_ALLOC, 13'd200, 13'd17);
    send_item(OP_ALLOC, 13'd100, 13'd17);
    send_item(OP_ALLOC, 13'd10, 13'd30);
    send_item(OP_ALLOC, 13'd1, 13'd1);
    send_item(OP_CLEAR, DIM_MAX, DIM_MAX);
    send_item(OP_ALLOC, 13'd256, 13'd62);
    send_item(OP_ALLOC, 13'd1, 13'd1);
  endtask

  task automatic test_position_wrap();
    set_page(COORD_TOP, COORD_TOP, 0);
    send_item(OP_ALLOC, 13'd5000, 13'd5000);
    send_item(OP_ALLOC, 13'd3000, 13'd3000);
    send_item(OP_ALLOC, 13'd3000, 13'd3000);
    send_item(OP_ALLOC, DIM_MAX, DIM_MAX);
    send_item(OP_CLEAR, 13'd0, 13'd0);
    send_item(OP_ALLOC, DIM_MAX, DIM_MAX);
  endtask

  task automatic test_unmapped_register();
    set_page(128, 128, 255);
    quiesce();
    write_reg(REG_UNMAPPED, '1);
    send_item(OP_ALLOC, 13'd128, 13'd128);
    send_item(OP_ALLOC, 13'd1, 13'd1);
    send_item(OP_ALLOC, 13'd129, 13'd1);
  endtask

  task automatic test_table_full();
    set_page(4096, 4096, 0);
    for (int i = 1; i <= SHELVES + 1; i++) begin
      send_item(OP_ALLOC, 13'd8, DIM_W'(i));
    end
    send_item(OP_ALLOC, 13'd8, 13'd1);
    send_item(OP_ALLOC, 13'd4096, 13'd1);
  endtask

  task automatic run_phase(input int width, input int height, input int pad,
                           input int items, input bit gaps);
    int               pick;
    int               w_top;
    int               h_top;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    set_page(width, height, pad);
    repeat (items) begin
      pick = $urandom_range(0, 99);
      w_top = (width / 6 > 1) ? width / 6 : 1;
      h_top = $urandom_range(0, 1) ? height / 8 : height / 128;
      if (h_top < 1) h_top = 1;
      if (pick < 5) begin
        send_item(OP_CLEAR, DIM_W'($urandom()), DIM_W'($urandom()));
      end else if (pick < 12) begin
        send_item(OP_ALLOC, DIM_W'($urandom()), DIM_W'($urandom()));
      end else if (pick < 16) begin
        w = $urandom_range(0, 1) ? '0 : DIM_W'($urandom_range(1, w_top));
        h = (w != '0) ? '0 : DIM_W'($urandom());
        send_item(OP_ALLOC, w, h);
      end else begin
        send_item(OP_ALLOC, DIM_W'($urandom_range(1, w_top)), DIM_W'($urandom_range(1, h_top)));
      end
      if (gaps && $urandom_range(0, 3) == 0) rest($urandom_range(1, 6));
    end
  endtask

  task automatic test_random_traffic();
    run_phase(4096, 4096, 0, 57, 1'b1);
    run_phase(4096, 4096, 255, 57, 1'b1);
    run_phase(32, 24, 1, 57, 1'b1);
    run_phase($urandom_range(64, 4096), $urandom_range(64, 4096), $urandom_range(0, 255),
              57, 1'b1);
    run_phase($urandom_range(1, 63), $urandom_range(1024, 4096), $urandom_range(0, 8),
              57, 1'b1);
    run_phase($urandom_range(64, 4096), $urandom_range(64, 4096), $urandom_range(0, 16),
              57, 1'b0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (placements_due.size() == 0) begin
        $error("result beat with no placement pending");
        errors++;
      end else begin
        due_now = placements_due.pop_front();
        if (out_granted !== due_now.granted) begin
          $error("granted: expected %0d, got %0d", due_now.granted, out_granted);
          errors++;
        end
        if (out_pos_x !== due_now.pos_x) begin
          $error("pos_x: expected %0d, got %0d", due_now.pos_x, out_pos_x);
          errors++;
        end
        if (out_pos_y !== due_now.pos_y) begin
          $error("pos_y: expected %0d, got %0d", due_now.pos_y, out_pos_y);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("shelf_best_fit_rect_packer_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_opcode     = OP_ALLOC;
    in_box_width  = '0;
    in_box_height = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    errors        = 0;
    empty_shelves();
    page_w_px = '0;
    page_h_px = '0;
    gutter_px = GUTTER_RESET;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_directed_shelves();
    test_position_wrap();
    test_unmapped_register();
    test_table_full();
    test_random_traffic();

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (placements_due.size() != 0) begin
      $error("%0d placements never answered", placements_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("shelf_best_fit_rect_packer_core regression: pass");
    end else begin
      $display("shelf_best_fit_rect_packer_core regression: fail");
    end
    $finish;
  end

endmodule
